// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRIO_W   = 16;
	localparam int TAG_W    = 32;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic   push;
		logic   pop;
		entry_t ent;
	} op_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg.
module spq_cell (
	input  logic            clk,
	input  spq_pkg::op_t    op,
	input  logic            occupied,
	input  logic            prev_gt,
	input  spq_pkg::entry_t prev_ent,
	input  spq_pkg::entry_t next_ent,
	output logic            gt,
	output spq_pkg::entry_t ent_q,
	output spq_pkg::entry_t ent_d
);

	// held entry outranks the incoming one: new word goes somewhere below
	assign gt = occupied && (ent_q.prio > op.ent.prio);

	always_comb begin
		ent_d = ent_q;
		priority if (op.push) begin
			if (!prev_gt) begin
				ent_d = prev_ent;
			end else if (!gt) begin
				ent_d = op.ent;
			end
		end else if (op.pop) begin
			ent_d = next_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: a chain of spq_cell slots,
// the entry count and the result register. Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (func, prio_in, tag_in) with in_valid / in_stall. func
//   selects push (0) or pop (1). Every accepted word yields exactly one result
//   word on the output channel (status, head_valid, head_prio, head_tag, count)
//   with out_valid / out_stall.
//   The result is registered: it appears the cycle after acceptance.
//   Throughput is one word per cycle unless out_stall holds a pending result;
//   the whole chain compares against the new priority in parallel and shifts
//   at once, so the result register is the only thing that limits the rate.
//   While a result waits and out_stall is high, in_stall is high; a word is
//   taken in the same cycle the pending result drains.
//   Reset (arst_n low) empties the queue and clears out_valid. Slot contents
//   are not cleared; only slots below the count are ever read.
//   Push on a full queue drops the word with status full; pop on an empty
//   queue reports status empty. Neither changes the queue.
module sorted_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] prio_in,
	input  logic [31:0] tag_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        head_valid,
	output logic [15:0] head_prio,
	output logic [31:0] head_tag,
	output logic [4:0]  count
);

	localparam int N = spq_pkg::CAPACITY;

	logic [spq_pkg::CNT_W-1:0] cnt_q;
	logic [spq_pkg::CNT_W-1:0] cnt_d;
	logic                      take;
	logic                      full;
	logic                      empty;
	logic [1:0]                st;
	spq_pkg::op_t              op;
	spq_pkg::entry_t           ent_q [N];
	spq_pkg::entry_t           ent_d [N];
	logic [N-1:0]              gt;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic                      head_valid_q;
	spq_pkg::entry_t           head_q;
	logic [spq_pkg::CNT_W-1:0] count_q;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;
	assign full     = (cnt_q == spq_pkg::CNT_W'(N));
	assign empty    = (cnt_q == '0);

	always_comb begin
		op.push     = 1'b0;
		op.pop      = 1'b0;
		op.ent.prio = prio_in;
		op.ent.tag  = tag_in;
		cnt_d       = cnt_q;
		st          = spq_pkg::ST_OK;
		if (take) begin
			unique case (func)
				spq_pkg::FUNC_PUSH: begin
					if (full) begin
						st = spq_pkg::ST_FULL;
					end else begin
						op.push = 1'b1;
						cnt_d   = cnt_q + 1'b1;
					end
				end
				spq_pkg::FUNC_POP: begin
					if (empty) begin
						st = spq_pkg::ST_EMPTY;
					end else begin
						op.pop = 1'b1;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				default: st = spq_pkg::ST_OK;
			endcase
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic            occ;
		logic            prev_gt;
		spq_pkg::entry_t prev_ent;
		spq_pkg::entry_t next_ent;

		assign occ = (spq_pkg::CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_first
			assign prev_gt  = 1'b1;
			assign prev_ent = '0;
		end else begin : g_rest
			assign prev_gt  = gt[i-1];
			assign prev_ent = ent_q[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_ent = ent_q[i];
		end else begin : g_mid
			assign next_ent = ent_q[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.op       (op),
			.occupied (occ),
			.prev_gt  (prev_gt),
			.prev_ent (prev_ent),
			.next_ent (next_ent),
			.gt       (gt[i]),
			.ent_q    (ent_q[i]),
			.ent_d    (ent_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word payload
	always_ff @(posedge clk) begin
		if (take) begin
			status_q     <= st;
			count_q      <= cnt_d;
			head_valid_q <= (cnt_d != '0);
			head_q       <= (cnt_d != '0) ? ent_d[0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign head_valid = head_valid_q;
	assign head_prio  = head_q.prio;
	assign head_tag   = head_q.tag;
	assign count      = 5'(count_q);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sorted_priority_queue_unit: a clocked driver and
// monitor around the block, with its own sorted-queue predictor.
// Depends on spq_pkg and the RTL of sorted_priority_queue_unit.
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        func;
		logic [15:0] prio;
		logic [31:0] tag;
		bit          wait_drain;
	} queue_word_t;

	typedef struct {
		logic [1:0]  status;
		logic        head_valid;
		logic [15:0] head_prio;
		logic [31:0] head_tag;
		logic [4:0]  count;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = spq_pkg::FUNC_PUSH;
	logic [15:0] prio_in = '0;
	logic [31:0] tag_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        head_valid;
	logic [15:0] head_prio;
	logic [31:0] head_tag;
	logic [4:0]  count;

	queue_word_t   word_backlog[$];
	queue_result_t due_results[$];

	// predictor state: slot 0 is the head
	logic [15:0] slot_prio[spq_pkg::CAPACITY];
	logic [31:0] slot_tag[spq_pkg::CAPACITY];
	int          held = 0;

	int idle_pct = 0;
	int stall_pct = 0;
	int words_in = 0;
	int words_out = 0;
	int errors = 0;
	int full_pushes = 0;
	int empty_pops = 0;
	int peak_held = 0;

	sorted_priority_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.prio_in(prio_in),
		.tag_in(tag_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.head_valid(head_valid),
		.head_prio(head_prio),
		.head_tag(head_tag),
		.count(count)
	);

	always #5 clk = ~clk;

	function automatic queue_result_t apply_queue_op(logic f, logic [15:0] p, logic [31:0] t);
		queue_result_t r;
		int pos;
		r.status = spq_pkg::ST_OK;
		if (f == spq_pkg::FUNC_PUSH) begin
			if (held >= spq_pkg::CAPACITY) begin
				r.status = spq_pkg::ST_FULL;
				full_pushes++;
			end else begin
				// new word lands ahead of held words of equal priority
				pos = 0;
				while (pos < held && slot_prio[pos] > p)
					pos++;
				for (int k = held; k > pos; k--) begin
					slot_prio[k] = slot_prio[k-1];
					slot_tag[k]  = slot_tag[k-1];
				end
				slot_prio[pos] = p;
				slot_tag[pos]  = t;
				held++;
				if (held > peak_held)
					peak_held = held;
			end
		end else begin
			if (held == 0) begin
				r.status = spq_pkg::ST_EMPTY;
				empty_pops++;
			end else begin
				for (int k = 1; k < held; k++) begin
					slot_prio[k-1] = slot_prio[k];
					slot_tag[k-1]  = slot_tag[k];
				end
				held--;
			end
		end
		r.head_valid = (held > 0);
		r.head_prio  = (held > 0) ? slot_prio[0] : 16'h0;
		r.head_tag   = (held > 0) ? slot_tag[0] : 32'h0;
		r.count      = 5'(held);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		if (errors <= 40)
			$display("[%0t] MISMATCH result %0d: %s", $realtime, words_out, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// driver: predicts each accepted word, then loads the next one from the backlog
	always @(posedge clk or negedge arst_n) begin : drive
		queue_word_t   nxt;
		queue_result_t res;
		logic          took;
		logic          gave;
		int            left;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			took = in_valid && !in_stall;
			gave = out_valid && !out_stall;
			left = words_in - words_out + int'(took) - int'(gave);
			if (took) begin
				res = apply_queue_op(func, prio_in, tag_in);
				due_results.push_back(res);
				words_in <= words_in + 1;
			end
			if (!in_valid || took) begin
				if (word_backlog.size() != 0 && !(word_backlog[0].wait_drain && left != 0) &&
				    $urandom_range(99) >= idle_pct) begin
					nxt = word_backlog.pop_front();
					in_valid <= 1'b1;
					func     <= nxt.func;
					prio_in  <= nxt.prio;
					tag_in   <= nxt.tag;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks every accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		queue_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_out <= words_out + 1;
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing pending");
				end else begin
					want = due_results.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("head_valid", 32'(head_valid), 32'(want.head_valid));
					check_field("head_prio", 32'(head_prio), 32'(want.head_prio));
					check_field("head_tag", head_tag, want.head_tag);
					check_field("count", 32'(count), 32'(want.count));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic add_word(logic f, logic [15:0] p, logic [31:0] t, bit drain = 1'b0);
		queue_word_t w;
		w.func = f;
		w.prio = p;
		w.tag = t;
		w.wait_drain = drain;
		word_backlog.push_back(w);
	endtask

	// runs of push-heavy, pop-heavy and mixed words, so the queue swings
	// between full and empty; priorities lean toward ties and extremes
	task automatic add_random(int n);
		int mode;
		int run_left;
		int pick;
		logic f;
		logic [15:0] p;
		mode = 0;
		run_left = 0;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				mode = $urandom_range(2);
				run_left = $urandom_range(8, 30);
			end
			unique case (mode)
				0: f = ($urandom_range(99) < 85) ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP;
				1: f = ($urandom_range(99) < 15) ? spq_pkg::FUNC_PUSH : spq_pkg::FUNC_POP;
				default: f = $urandom_range(1) ? spq_pkg::FUNC_POP : spq_pkg::FUNC_PUSH;
			endcase
			pick = $urandom_range(7);
			if (pick < 2)
				p = 16'($urandom_range(3));
			else if (pick == 2)
				p = $urandom_range(1) ? 16'hffff : 16'h0000;
			else
				p = 16'($urandom_range(65535));
			add_word(f, p, $urandom(), $urandom_range(49) == 0);
			run_left--;
		end
	endtask

	task automatic run_phase(int idle, int stall);
		idle_pct <= idle;
		stall_pct <= stall;
		@(negedge clk);
		while (word_backlog.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pop, extremes, ties at head and tail, drain to empty
		add_word(spq_pkg::FUNC_POP, 16'h1234, 32'h89abcdef);
		add_word(spq_pkg::FUNC_PUSH, 16'h0000, 32'h00000000);
		add_word(spq_pkg::FUNC_PUSH, 16'hffff, 32'hffffffff);
		add_word(spq_pkg::FUNC_PUSH, 16'hffff, 32'ha5a5a5a5);
		add_word(spq_pkg::FUNC_PUSH, 16'h8000, 32'h80000001);
		add_word(spq_pkg::FUNC_PUSH, 16'h0000, 32'h5a5a5a5a);
		add_word(spq_pkg::FUNC_PUSH, 16'h7fff, 32'h7fffffff);
		for (int i = 0; i < 6; i++)
			add_word(spq_pkg::FUNC_POP, 16'hffff, 32'hffffffff);
		add_word(spq_pkg::FUNC_POP, 16'h0000, 32'h0);
		add_word(spq_pkg::FUNC_PUSH, 16'h0001, 32'h00000001, 1'b1);
		add_word(spq_pkg::FUNC_PUSH, 16'h0001, 32'h00000002);
		add_word(spq_pkg::FUNC_POP, 16'h0000, 32'h0);
		add_word(spq_pkg::FUNC_POP, 16'h0000, 32'h0);
		add_random(95);
		run_phase(0, 0);

		add_word(spq_pkg::FUNC_PUSH, 16'($urandom_range(65535)), $urandom(), 1'b1);
		add_random(95);
		run_phase(81, 0);

		add_word(spq_pkg::FUNC_POP, 16'($urandom_range(65535)), $urandom(), 1'b1);
		add_random(95);
		run_phase(0, 81);

		add_word(spq_pkg::FUNC_PUSH, 16'($urandom_range(65535)), $urandom(), 1'b1);
		add_random(95);
		run_phase(34, 34);

		while (due_results.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);

		$display("Ran %0d words through %0d idle/stall phases; %0d results checked.",
			words_in, 4, words_out);
		$display("Saw %0d pushes on a full queue, %0d pops on an empty one, peak depth %0d.",
			full_pushes, empty_pops, peak_held);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d results still due", due_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
